// ----- rtl/ptkw_pkg.sv -----
// ----------------------------------------------------------------------------
// ptkw_pkg
// Shared types and constants of the packed trie key walker.
// ----------------------------------------------------------------------------
package ptkw_pkg;

   // Byte address width of the dictionary image; pointers wrap to it.
   localparam int DICT_ADDR_BITS = 20;

   typedef logic [DICT_ADDR_BITS-1:0] dict_addr_type;

   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_RESTART = 2'd1,
      CMD_STEP    = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      RES_FAIL     = 2'd0,
      RES_MATCH    = 2'd1,
      RES_WORD_END = 2'd2,
      RES_DONE     = 2'd3
   } result_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RST_FLAGS,
      S_RST_COUNT,
      S_SUF_CMP,
      S_BR_PROBE,
      S_BR_CMP,
      S_PTR_LO,
      S_PTR_MID,
      S_PTR_HI,
      S_PTR_TOP,
      S_HDR_FLAGS,
      S_HDR_COUNT,
      S_FINISH
   } walk_state_type;

endpackage

// ----- rtl/ptkw_ram.sv -----
// ----------------------------------------------------------------------------
// ptkw_ram
// Single-port synchronous RAM, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module ptkw_ram #(
   parameter int ADDR_BITS = 20,
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 write_enable,
   input  logic [ADDR_BITS-1:0] address,
   input  logic [DATA_BITS-1:0] write_data,
   output logic [DATA_BITS-1:0] read_data
);

   logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
   logic [DATA_BITS-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[address] <= write_data;
      end
      read_data_ff <= mem[address];
   end

   assign read_data = read_data_ff;

endmodule

// ----- rtl/packed_trie_key_walker.sv -----
// ----------------------------------------------------------------------------
// packed_trie_key_walker
// Holds a packed trie image in a byte-wide RAM and walks it one key byte per
// step item: suffix nodes compare stored bytes, branch nodes binary-search
// four-byte entries, and a match follows a 24-bit pointer to the next node.
// ----------------------------------------------------------------------------
//
//   channel  direction  tuser      tdata
//   req      in         cmd        write_address, write_byte, key_byte
//   rsp      out        -          walk_result
//
// Every dictionary byte goes through one RAM port with a registered read, so
// an item takes longer the more bytes it reads: restart reads two header
// bytes, a suffix step one byte, a branch step one byte per probe (up to 8
// probes); the end of a suffix or a branch match also reads a 3-byte pointer
// and the two header bytes of the next node.
// A new item is taken only in idle; a finished result waits in the output
// register, and the block stalls in its finish state while that register is
// full and not taken. Synchronous reset puts the walker at position 1 with
// an empty branch node; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module packed_trie_key_walker
   import ptkw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // cmd
   input  logic [39:0] req_tdata,   // write_address[19:0], write_byte[27:20],
                                    // key_byte[35:28], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // walk_result[1:0], zero pad
);

   walk_state_type state_ff, state_in;
   dict_addr_type  pos_ff, pos_in;
   logic [7:0]     off_ff, off_in;
   logic [7:0]     cnt_ff, cnt_in;
   logic           suffix_ff, suffix_in;
   logic [7:0]     key_ff, key_in;
   dict_addr_type  base_ff, base_in;
   logic [15:0]    ptr_ff, ptr_in;
   dict_addr_type  target_ff, target_in;
   logic [1:0]     flags_ff, flags_in;
   logic [7:0]     lo_ff, lo_in;
   logic [7:0]     end_ff, end_in;
   logic [7:0]     mid_ff, mid_in;
   result_type     res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   result_type     rsp_result_ff, rsp_result_in;

   logic           ram_we;
   dict_addr_type  ram_addr;
   logic [7:0]     ram_rdata;
   logic [7:0]     off_next;
   logic [8:0]     mid_sum;

   // Byte address of a node's body: position plus header plus offset, wrapped.
   function automatic dict_addr_type body_addr(dict_addr_type pos, logic [9:0] offset);
      body_addr = pos + dict_addr_type'(2) + dict_addr_type'(offset);
   endfunction

   ptkw_ram #(
      .ADDR_BITS(DICT_ADDR_BITS),
      .DATA_BITS(8)
   ) u_ram (
      .clock       (clock),
      .write_enable(ram_we),
      .address     (ram_addr),
      .write_data  (req_tdata[27:20]),
      .read_data   (ram_rdata)
   );

   assign off_next = off_ff + 8'd1;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, end_ff} - 9'd1;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      off_in        = off_ff;
      cnt_in        = cnt_ff;
      suffix_in     = suffix_ff;
      key_in        = key_ff;
      base_in       = base_ff;
      ptr_in        = ptr_ff;
      target_in     = target_ff;
      flags_in      = flags_ff;
      lo_in         = lo_ff;
      end_in        = end_ff;
      mid_in        = mid_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_result_in = rsp_result_ff;
      ram_we        = 1'b0;
      ram_addr      = '0;
      req_tready    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in = req_tdata[35:28];
               case (cmd_type'(req_tuser))
                  CMD_WRITE: begin
                     ram_we   = 1'b1;
                     ram_addr = dict_addr_type'(req_tdata[19:0]);
                     res_in   = RES_DONE;
                     state_in = S_FINISH;
                  end
                  CMD_RESTART: begin
                     ram_addr = '0;
                     state_in = S_RST_FLAGS;
                  end
                  CMD_STEP: begin
                     if (suffix_ff) begin
                        ram_addr = body_addr(pos_ff, {2'b00, off_ff});
                        state_in = S_SUF_CMP;
                     end else begin
                        lo_in    = 8'd0;
                        end_in   = cnt_ff;
                        state_in = S_BR_PROBE;
                     end
                  end
                  default: begin
                     res_in   = RES_FAIL;
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_RST_FLAGS: begin
            suffix_in = ram_rdata[1];
            ram_addr  = dict_addr_type'(2);
            state_in  = S_RST_COUNT;
         end
         S_RST_COUNT: begin
            cnt_in    = ram_rdata;
            pos_in    = dict_addr_type'(1);
            off_in    = 8'd0;
            res_in    = RES_DONE;
            state_in  = S_FINISH;
         end
         S_SUF_CMP: begin
            if (ram_rdata != key_ff) begin
               res_in   = RES_FAIL;
               state_in = S_FINISH;
            end else if (off_next == cnt_ff) begin
               // end of suffix: the pointer follows the last suffix byte
               base_in  = body_addr(pos_ff, {2'b00, off_next});
               state_in = S_PTR_LO;
            end else begin
               off_in   = off_next;
               res_in   = RES_MATCH;
               state_in = S_FINISH;
            end
         end
         S_BR_PROBE: begin
            // search window is lo up to, not including, end
            if (lo_ff >= end_ff) begin
               res_in   = RES_FAIL;
               state_in = S_FINISH;
            end else begin
               mid_in   = mid_sum[8:1];
               ram_addr = body_addr(pos_ff, {mid_sum[8:1], 2'b00});
               state_in = S_BR_CMP;
            end
         end
         S_BR_CMP: begin
            if (key_ff < ram_rdata) begin
               end_in   = mid_ff;
               state_in = S_BR_PROBE;
            end else if (key_ff > ram_rdata) begin
               lo_in    = mid_ff + 8'd1;
               state_in = S_BR_PROBE;
            end else begin
               base_in  = body_addr(pos_ff, {mid_ff, 2'b01});
               state_in = S_PTR_LO;
            end
         end
         S_PTR_LO: begin
            ram_addr = base_ff;
            state_in = S_PTR_MID;
         end
         S_PTR_MID: begin
            ptr_in[7:0] = ram_rdata;
            ram_addr    = base_ff + dict_addr_type'(1);
            state_in    = S_PTR_HI;
         end
         S_PTR_HI: begin
            ptr_in[15:8] = ram_rdata;
            ram_addr     = base_ff + dict_addr_type'(2);
            state_in     = S_PTR_TOP;
         end
         S_PTR_TOP: begin
            target_in = dict_addr_type'({ram_rdata, ptr_ff});
            ram_addr  = dict_addr_type'({ram_rdata, ptr_ff});
            state_in  = S_HDR_FLAGS;
         end
         S_HDR_FLAGS: begin
            flags_in = ram_rdata[1:0];
            ram_addr = target_ff + dict_addr_type'(1);
            state_in = S_HDR_COUNT;
         end
         S_HDR_COUNT: begin
            cnt_in    = ram_rdata;
            pos_in    = target_ff;
            suffix_in = flags_ff[1];
            off_in    = 8'd0;
            res_in    = flags_ff[0] ? RES_WORD_END : RES_MATCH;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= dict_addr_type'(1);
         off_ff       <= 8'd0;
         cnt_ff       <= 8'd0;
         suffix_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         off_ff       <= off_in;
         cnt_ff       <= cnt_in;
         suffix_ff    <= suffix_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      base_ff       <= base_in;
      ptr_ff        <= ptr_in;
      target_ff     <= target_in;
      flags_ff      <= flags_in;
      lo_ff         <= lo_in;
      end_ff        <= end_in;
      mid_ff        <= mid_in;
      res_ff        <= res_in;
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_result_ff};

endmodule

// ----- tb/packed_trie_key_walker_tb.sv -----
// ----------------------------------------------------------------------------
// packed_trie_key_walker_tb
// Self-checking bench for the packed trie key walker. It loads small random
// tries into the dictionary through write items and walks them with restart
// and step items. Most keys follow the stored paths and the rest are noise.
// A scoreboard class predicts every walk result and compares each response
// item in order. Both channels idle at random, with some phases at full rate.
// ----------------------------------------------------------------------------
module packed_trie_key_walker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ptkw_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         DRAIN_CYCLES = 64;
   localparam int         ITEM_TARGET = 950;
   localparam int         REPORT_CAP  = 100;

   class walk_scoreboard;
      logic [7:0]    dict_img [dict_addr_type];
      dict_addr_type node_pos;
      logic [7:0]    suf_off;
      logic [7:0]    node_cnt;
      logic          node_suf;
      bit            miss;
      result_type    due_results [$];
      int            errors;
      int            seen;

      function new();
         node_pos = 1;
         suf_off  = 0;
         node_cnt = 0;
         node_suf = 0;
         errors   = 0;
         seen     = 0;
      endfunction

      function logic [7:0] fetch(dict_addr_type a);
         if (!dict_img.exists(a)) begin
            miss = 1'b1;
            return 8'd0;
         end
         return dict_img[a];
      endfunction

      function dict_addr_type fetch_ptr(dict_addr_type a);
         logic [7:0]    b0;
         logic [7:0]    b1;
         logic [7:0]    b2;
         dict_addr_type t;
         b0 = fetch(a);
         t  = a + 1;
         b1 = fetch(t);
         t  = a + 2;
         b2 = fetch(t);
         // drop the pointer bits above the address width
         return {b2[3:0], b1, b0};
      endfunction

      function result_type enter_node(dict_addr_type target);
         logic [7:0]    flags;
         dict_addr_type t;
         flags    = fetch(target);
         t        = target + 1;
         node_pos = target;
         node_suf = flags[1];
         node_cnt = fetch(t);
         suf_off  = 0;
         return flags[0] ? RES_WORD_END : RES_MATCH;
      endfunction

      function result_type step_key(logic [7:0] key);
         dict_addr_type at;
         logic [7:0]    nxt;
         logic [7:0]    probe;
         int            lo;
         int            hi;
         int            mid;
         if (node_suf) begin
            at = node_pos + 2 + suf_off;
            if (fetch(at) != key) return RES_FAIL;
            nxt = suf_off + 1;
            if (nxt == node_cnt) begin
               at = node_pos + 2 + nxt;
               return enter_node(fetch_ptr(at));
            end
            suf_off = nxt;
            return RES_MATCH;
         end
         lo = 0;
         hi = int'(node_cnt) - 1;
         while (lo <= hi) begin
            mid   = (lo + hi) / 2;
            at    = node_pos + 2 + mid * 4;
            probe = fetch(at);
            if (key < probe) hi = mid - 1;
            else if (key > probe) lo = mid + 1;
            else begin
               at = at + 1;
               return enter_node(fetch_ptr(at));
            end
         end
         return RES_FAIL;
      endfunction

      function result_type walk_outcome(logic [1:0] cmd, dict_addr_type addr,
                                        logic [7:0] wbyte, logic [7:0] key);
         logic [7:0] flags;
         case (cmd)
            CMD_WRITE: begin
               dict_img[addr] = wbyte;
               return RES_DONE;
            end
            CMD_RESTART: begin
               flags    = fetch(0);
               node_pos = 1;
               suf_off  = 0;
               node_suf = flags[1];
               node_cnt = fetch(2);
               return RES_DONE;
            end
            CMD_STEP: return step_key(key);
            default:  return RES_FAIL;
         endcase
      endfunction

      // Dry run: tell whether the item reads only bytes that were written.
      function bit safe_to_send(logic [1:0] cmd, logic [7:0] key);
         dict_addr_type p;
         logic [7:0]    o;
         logic [7:0]    c;
         logic          s;
         if (cmd == CMD_WRITE) return 1'b1;
         p    = node_pos;
         o    = suf_off;
         c    = node_cnt;
         s    = node_suf;
         miss = 1'b0;
         void'(walk_outcome(cmd, '0, '0, key));
         node_pos = p;
         suf_off  = o;
         node_cnt = c;
         node_suf = s;
         return !miss;
      endfunction

      // Key that the current node accepts, taken from the stored image.
      function logic [7:0] lookup_key(output bit found);
         dict_addr_type at;
         int            i;
         found = 1'b0;
         if (node_suf) at = node_pos + 2 + suf_off;
         else if (node_cnt != 0) begin
            i  = $urandom_range(0, node_cnt - 1);
            at = node_pos + 2 + 4 * i;
         end else return $urandom;
         if (!dict_img.exists(at)) return $urandom;
         found = 1'b1;
         return dict_img[at];
      endfunction

      function void note_item(logic [1:0] cmd, dict_addr_type addr,
                              logic [7:0] wbyte, logic [7:0] key);
         due_results.push_back(walk_outcome(cmd, addr, wbyte, key));
      endfunction

      task report(string msg);
         errors++;
         if (errors <= REPORT_CAP) $display("ERROR: %s", msg);
      endtask

      task check_result(logic [7:0] data);
         result_type want;
         seen++;
         if (due_results.size() == 0) begin
            report($sformatf("response %0d arrived with nothing due", seen));
         end else begin
            want = due_results.pop_front();
            if (data[1:0] !== want)
               report($sformatf("response %0d: walk_result %0d, predicted %0d",
                                seen, data[1:0], want));
         end
      endtask
   endclass

   typedef struct {
      dict_addr_type addr;
      logic [7:0]    data;
   } dict_write_type;

   typedef struct {
      dict_addr_type pos;
      bit            is_suffix;
      bit            word_end;
      int            count;
      int            depth;
   } trie_node_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   walk_scoreboard sb;
   int             cycles = 0;
   int             items_sent = 0;
   bit             tx_burst = 1'b0;
   bit             rx_burst = 1'b0;

   dict_write_type image_q [$];
   trie_node_type  todo_q [$];
   bit             placed [dict_addr_type];
   dict_addr_type  cursor;
   int             budget;
   bit             long_chain;
   int             wide_count;

   packed_trie_key_walker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) cycles <= cycles + 1;

   initial begin
      while (cycles <= CYCLE_LIMIT) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------- trie build

   function automatic void put_byte(dict_addr_type a, logic [7:0] d);
      image_q.push_back('{a, d});
      placed[a] = 1'b1;
   endfunction

   function automatic void put_ptr(dict_addr_type a, dict_addr_type target);
      dict_addr_type t;
      logic [3:0]    junk;
      junk = $urandom;
      put_byte(a, target[7:0]);
      t = a + 1;
      put_byte(t, target[15:8]);
      t = a + 2;
      put_byte(t, {junk, target[19:16]});
   endfunction

   // Reserve a free span, wrapping at the top of the address space.
   function automatic dict_addr_type place(int nbytes);
      dict_addr_type t;
      dict_addr_type a;
      bit            clash;
      int            i;
      do begin
         clash = 1'b0;
         for (i = 0; i < nbytes; i++) begin
            t = cursor + i;
            if (placed.exists(t)) clash = 1'b1;
         end
         if (clash) cursor = cursor + 1;
      end while (clash);
      for (i = 0; i < nbytes; i++) begin
         t = cursor + i;
         placed[t] = 1'b1;
      end
      a      = cursor;
      cursor = cursor + nbytes;
      return a;
   endfunction

   function automatic dict_addr_type plan_node(int depth);
      trie_node_type n;
      int            nbytes;
      int            i;
      dict_addr_type t;
      n.depth    = depth;
      n.word_end = $urandom_range(0, 1);
      if (long_chain) begin
         n.is_suffix = (depth < 2);
         n.count     = (depth == 0) ? 1 : 0;
      end else if (depth >= 3 || budget <= 0) begin
         n.is_suffix = 1'b0;
         n.count     = 0;
      end else begin
         n.is_suffix = ($urandom_range(0, 2) == 0);
         if (n.is_suffix) n.count = $urandom_range(1, 5);
         else if (depth == 0 && wide_count > 0) n.count = wide_count;
         else n.count = $urandom_range(1, 5);
         budget--;
      end
      if (!n.is_suffix) nbytes = 2 + 4 * n.count;
      else if (n.count == 0) nbytes = 258;
      else nbytes = n.count + 5;
      if (depth == 0) begin
         // root: flags at 0, count at 2, body from 3
         n.pos = 1;
         for (i = 0; i <= nbytes; i++) begin
            t = i;
            placed[t] = 1'b1;
         end
      end else begin
         n.pos = place(nbytes);
      end
      todo_q.push_back(n);
      return n.pos;
   endfunction

   function automatic void fill_node(trie_node_type n);
      dict_addr_type at;
      dict_addr_type child;
      bit            used [256];
      int            len;
      int            picked;
      int            i;
      int            k;
      at = (n.depth == 0) ? dict_addr_type'(0) : n.pos;
      put_byte(at, {6'd0, n.is_suffix, n.word_end});
      at = n.pos + 1;
      put_byte(at, 8'(n.count));
      if (n.is_suffix) begin
         len   = (n.count == 0) ? 256 : n.count;
         child = plan_node(n.depth + 1);
         // a count-zero suffix wraps its offset, so the pointer overlays bytes 0..2
         at = n.pos + 2 + n.count;
         put_ptr(at, child);
         for (i = 0; i < len; i++) begin
            at = n.pos + 2 + i;
            if (n.count != 0 || i >= 3) put_byte(at, $urandom);
         end
      end else begin
         for (k = 0; k < 256; k++) used[k] = 1'b0;
         picked = 0;
         if (n.count >= 2 && $urandom_range(0, 2) == 0) begin
            used[0]   = 1'b1;
            used[255] = 1'b1;
            picked    = 2;
         end
         while (picked < n.count) begin
            k = $urandom_range(0, 255);
            if (!used[k]) begin
               used[k] = 1'b1;
               picked++;
            end
         end
         i = 0;
         for (k = 0; k < 256; k++) begin
            if (used[k]) begin
               at = n.pos + 2 + 4 * i;
               put_byte(at, 8'(k));
               child = plan_node(n.depth + 1);
               at    = at + 1;
               put_ptr(at, child);
               i++;
            end
         end
      end
   endfunction

   function automatic void build_trie(dict_addr_type base);
      image_q.delete();
      todo_q.delete();
      placed.delete();
      cursor = base;
      budget = 10;
      void'(plan_node(0));
      while (todo_q.size() != 0) fill_node(todo_q.pop_front());
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic send(logic [1:0] cmd, dict_addr_type addr, logic [7:0] wbyte,
                       logic [7:0] key);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'd0, key, wbyte, addr};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_item(cmd, addr, wbyte, key);
      items_sent++;
   endtask

   task automatic send_write(dict_addr_type addr, logic [7:0] data);
      send(CMD_WRITE, addr, data, $urandom);
   endtask

   task automatic send_restart();
      send(CMD_RESTART, $urandom, $urandom, $urandom);
   endtask

   task automatic send_step(logic [7:0] key);
      send(CMD_STEP, $urandom, $urandom, key);
   endtask

   // Hold the request side until every due response is back.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
   endtask

   task automatic follow_chain();
      logic [7:0] key;
      bit         found;
      int         i;
      send_restart();
      for (i = 0; i < 300; i++) begin
         key = sb.lookup_key(found);
         if (!found || !sb.safe_to_send(CMD_STEP, key)) break;
         send_step(key);
      end
   endtask

   task automatic walk_items(int count);
      logic [7:0] key;
      logic [1:0] cmd;
      bit         found;
      int         r;
      int         i;
      for (i = 0; i < count; i++) begin
         r   = $urandom_range(0, 99);
         key = sb.lookup_key(found);
         if (r < 4) cmd = CMD_WRITE;
         else if (r < 7) cmd = CMD_UNUSED;
         else if (r < 17 || (!found && r < 60)) cmd = CMD_RESTART;
         else begin
            cmd = CMD_STEP;
            if (r < 27) key = $urandom;
         end
         // steer away from anything that would read an unwritten byte
         if (!sb.safe_to_send(cmd, key)) cmd = CMD_RESTART;
         if (!sb.safe_to_send(cmd, key)) cmd = CMD_WRITE;
         send(cmd, $urandom, $urandom, key);
      end
   endtask

   // ---------------------------------------------------------------- receiver

   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = rx_burst ? 0 : $urandom_range(0, 16);
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         sb.check_result(rsp_tdata);
      end
   end

   // ---------------------------------------------------------------- main

   initial begin
      int phase;
      sb = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty branch after reset, unused command with every field high
      send_step(8'hFF);
      send(CMD_UNUSED, 20'hFFFFF, 8'hFF, 8'hFF);
      send_write(20'hFFFFF, 8'hFF);
      send_write(20'h00000, 8'h00);
      send_write(20'h00002, 8'h00);
      send_restart();
      send_step(8'h00);
      // suffix root whose pointer lands on a node straddling the top address
      send_write(20'h00000, 8'h02);
      send_write(20'h00002, 8'h01);
      send_write(20'h00003, 8'hFF);
      send_write(20'h00004, 8'hFE);
      send_write(20'h00005, 8'hFF);
      send_write(20'h00006, 8'hFF);
      send_write(20'hFFFFE, 8'h03);
      send_write(20'hFFFFF, 8'h01);
      send_write(20'h00001, 8'h10);
      send_write(20'hF0110, 8'h01);
      send_write(20'hF0111, 8'h00);
      send_restart();
      send_step(8'hFF);
      send_step(8'h02);
      send_step(8'h00);
      drain();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         tx_burst   = ($urandom_range(0, 3) == 0);
         rx_burst   = ($urandom_range(0, 3) == 0);
         long_chain = (phase == 1);
         wide_count = (phase == 2) ? 31 : 0;
         if (phase == 0) build_trie(20'hFFFFF - $urandom_range(0, 24));
         else build_trie($urandom);
         foreach (image_q[j]) send_write(image_q[j].addr, image_q[j].data);
         if (long_chain) follow_chain();
         walk_items($urandom_range(40, 70));
         drain();
         phase++;
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.due_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
